[src/vbt_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the block allocation table read translator.
// No dependencies.
package vbt_pkg;

	localparam int unsigned TIDX_W   = 14;
	localparam int unsigned ENTRY_W  = 47;
	localparam int unsigned OFF_W    = 44;
	localparam int unsigned COUNT_W  = 29;

	localparam logic [1:0] CFG_BLOCK_SHIFT = 2'd0;
	localparam logic [1:0] CFG_CHUNK_SHIFT = 2'd1;
	localparam logic [1:0] CFG_DISK_SIZE   = 2'd2;
	localparam logic [1:0] CFG_TABLE_COUNT = 2'd3;

	localparam logic [2:0] ST_ZERO    = 3'd0;
	localparam logic [2:0] ST_READ    = 3'd1;
	localparam logic [2:0] ST_END     = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_PARTIAL = 3'd4;
	localparam logic [2:0] ST_WRITTEN = 3'd5;

	localparam logic [2:0] PAY_FULL    = 3'd6;
	localparam logic [2:0] PAY_PARTIAL = 3'd7;

	localparam logic       CMD_WRITE = 1'b0;

	localparam logic [4:0] BS_MIN = 5'd9;
	localparam logic [4:0] BS_MAX = 5'd28;
	localparam logic [4:0] BS_RST = 5'd20;
	localparam logic [4:0] CS_RST = 5'd3;

endpackage

[src/vbt_req_if.sv]
`timescale 1ns / 1ps
// Request channel: table writes and translate requests.
// No dependencies.
interface vbt_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [11:0] entry_index;
	logic [63:0] entry_word;
	logic [63:0] virtual_offset;
	logic [31:0] bytes_wanted;

	modport source (output valid, cmd, entry_index, entry_word, virtual_offset,
		bytes_wanted, input ready);
	modport sink (input valid, cmd, entry_index, entry_word, virtual_offset,
		bytes_wanted, output ready);
endinterface

[src/vbt_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: one segment descriptor or status per request.
// No dependencies.
interface vbt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] file_pos;
	logic [28:0] byte_count;

	modport source (output valid, status, file_pos, byte_count, input ready);
	modport sink (input valid, status, file_pos, byte_count, output ready);
endinterface

[src/vbt_table.sv]
`timescale 1ns / 1ps
// Allocation table storage: one write port, one registered read port.
// Uses vbt_pkg.
module vbt_table #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [vbt_pkg::ENTRY_W-1:0]   wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [vbt_pkg::ENTRY_W-1:0]   rdata
);

	logic [vbt_pkg::ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/vhdx_bat_read_translator.sv]
`timescale 1ns / 1ps
// Block allocation table read translator, top level.
// Uses vbt_pkg, vbt_req_if, vbt_rsp_if, vbt_table.
//
//   channel  dir  payload
//   req      in   cmd, entry_index, entry_word, virtual_offset, bytes_wanted
//   rsp      out  status, file_pos, byte_count
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One request per cycle while not stalled; each request passes the stages below in order.
// Stages: capture, offset subtract and block shift, index add and table read,
// descriptor build into the response register.
// Whole pipeline holds while the response register is full and not taken.
// Reset clears valids and returns config to its reset values; the table is undefined until written.
module vhdx_bat_read_translator #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	vbt_req_if.sink     req,
	vbt_rsp_if.source   rsp
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [2:0] {K_WRITE, K_END, K_EMPTY, K_RANGE, K_LOOKUP} kind_t;

	logic [4:0]  block_shift_q;
	logic [4:0]  chunk_shift_q;
	logic [63:0] disk_size_q;
	logic [12:0] table_count_q;
	logic [4:0]  bs_clamped;

	always_comb begin
		bs_clamped = cfg_data[4:0];
		if (cfg_data[4:0] < vbt_pkg::BS_MIN) begin
			bs_clamped = vbt_pkg::BS_MIN;
		end else if (cfg_data[4:0] > vbt_pkg::BS_MAX) begin
			bs_clamped = vbt_pkg::BS_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_shift_q <= vbt_pkg::BS_RST;
			chunk_shift_q <= vbt_pkg::CS_RST;
			disk_size_q   <= '0;
			table_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				vbt_pkg::CFG_BLOCK_SHIFT: block_shift_q <= bs_clamped;
				vbt_pkg::CFG_CHUNK_SHIFT: chunk_shift_q <= cfg_data[4:0];
				vbt_pkg::CFG_DISK_SIZE:   disk_size_q   <= cfg_data;
				vbt_pkg::CFG_TABLE_COUNT: table_count_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic adv;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= req.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// stage 1: capture
	logic                         cmd_s1;
	logic [11:0]                  idx_s1;
	logic [vbt_pkg::OFF_W-1:0]    off_s1;
	logic [2:0]                   pst_s1;
	logic [63:0]                  voff_s1;
	logic [31:0]                  want_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= req.cmd;
			idx_s1  <= req.entry_index;
			off_s1  <= req.entry_word[63:20];
			pst_s1  <= req.entry_word[2:0];
			voff_s1 <= req.virtual_offset;
			want_s1 <= req.bytes_wanted;
		end
	end

	// stage 1 logic: distance to end, in-block offset, block number
	logic [64:0]                  diff;
	logic [28:0]                  bsize;
	logic [27:0]                  inblk_c;
	logic [63:0]                  blk;

	assign diff    = {1'b0, disk_size_q} - {1'b0, voff_s1};
	assign bsize   = 29'(1) << block_shift_q;
	assign inblk_c = voff_s1[27:0] & (bsize[27:0] - 28'd1);
	assign blk     = voff_s1 >> block_shift_q;

	logic                         cmd_s2;
	logic [11:0]                  idx_s2;
	logic [vbt_pkg::OFF_W-1:0]    off_s2;
	logic [2:0]                   pst_s2;
	logic [31:0]                  want_s2;
	logic [63:0]                  rem_s2;
	logic                         end_s2;
	logic [27:0]                  inblk_s2;
	logic [28:0]                  canraw_s2;
	logic [12:0]                  blk_s2;
	logic                         big_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2    <= cmd_s1;
			idx_s2    <= idx_s1;
			off_s2    <= off_s1;
			pst_s2    <= pst_s1;
			want_s2   <= want_s1;
			rem_s2    <= diff[63:0];
			end_s2    <= diff[64] || (diff[63:0] == 64'd0);
			inblk_s2  <= inblk_c;
			canraw_s2 <= bsize - {1'b0, inblk_c};
			blk_s2    <= blk[12:0];
			big_s2    <= |blk[63:13];
		end
	end

	// stage 2 logic: clamp length, table index, range check, table access
	logic [31:0]                  len;
	logic [28:0]                  can_c;
	logic [vbt_pkg::TIDX_W-1:0]   tidx;
	logic                         out_range;
	logic                         wr_ok;
	kind_t                        kind_c;

	assign len   = ((rem_s2[63:32] != 32'd0) || (want_s2 <= rem_s2[31:0])) ?
		want_s2 : rem_s2[31:0];
	assign can_c = ({3'b000, canraw_s2} > len) ? len[28:0] : canraw_s2;
	assign tidx  = {1'b0, blk_s2} + {1'b0, blk_s2 >> chunk_shift_q};
	assign out_range = big_s2 || (tidx >= {1'b0, table_count_q}) ||
		(32'(tidx) >= TABLE_DEPTH);
	assign wr_ok = 32'(idx_s2) < TABLE_DEPTH;

	always_comb begin
		if (cmd_s2 == vbt_pkg::CMD_WRITE) begin
			kind_c = K_WRITE;
		end else if (end_s2) begin
			kind_c = K_END;
		end else if (want_s2 == 32'd0) begin
			kind_c = K_EMPTY;
		end else if (out_range) begin
			kind_c = K_RANGE;
		end else begin
			kind_c = K_LOOKUP;
		end
	end

	logic [vbt_pkg::ENTRY_W-1:0]  rdata;

	vbt_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (adv && v_s2 && (cmd_s2 == vbt_pkg::CMD_WRITE) && wr_ok),
		.waddr (AW'(idx_s2)),
		.wdata ({off_s2, pst_s2}),
		.re    (adv),
		.raddr (AW'(tidx)),
		.rdata (rdata)
	);

	kind_t                        kind_s3;
	logic [27:0]                  inblk_s3;
	logic [28:0]                  can_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3  <= kind_c;
			inblk_s3 <= inblk_s2;
			can_s3   <= can_c;
		end
	end

	// stage 3 logic: build descriptor from the table entry
	logic [63:0]                  foff;
	logic [2:0]                   st_c;
	logic [63:0]                  fo_c;
	logic [28:0]                  cnt_c;

	assign foff = {rdata[vbt_pkg::ENTRY_W-1:3], 20'd0} + 64'(inblk_s3);

	always_comb begin
		st_c  = vbt_pkg::ST_ZERO;
		fo_c  = '0;
		cnt_c = '0;
		case (kind_s3)
			K_WRITE: st_c = vbt_pkg::ST_WRITTEN;
			K_END:   st_c = vbt_pkg::ST_END;
			K_EMPTY: st_c = vbt_pkg::ST_ZERO;
			K_RANGE: st_c = vbt_pkg::ST_RANGE;
			K_LOOKUP: begin
				if (rdata[2:0] == vbt_pkg::PAY_PARTIAL) begin
					st_c = vbt_pkg::ST_PARTIAL;
				end else if ((rdata[2:0] == vbt_pkg::PAY_FULL) && (foff != 64'd0)) begin
					st_c  = vbt_pkg::ST_READ;
					fo_c  = foff;
					cnt_c = can_s3;
				end else begin
					cnt_c = can_s3;
				end
			end
			default: st_c = vbt_pkg::ST_ZERO;
		endcase
	end

	logic [2:0]                   status_q;
	logic [63:0]                  file_pos_q;
	logic [28:0]                  byte_count_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q     <= st_c;
			file_pos_q   <= fo_c;
			byte_count_q <= cnt_c;
		end
	end

	assign rsp.status     = status_q;
	assign rsp.file_pos   = file_pos_q;
	assign rsp.byte_count = byte_count_q;

`ifndef ASSERT_OFF
	a_err_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == vbt_pkg::ST_END || status_q == vbt_pkg::ST_RANGE ||
		status_q == vbt_pkg::ST_PARTIAL || status_q == vbt_pkg::ST_WRITTEN)
		|-> byte_count_q == 29'd0)
		else $error("error status with nonzero byte count");

	a_offset_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != vbt_pkg::ST_READ) |-> file_pos_q == 64'd0)
		else $error("file offset set without file read");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> byte_count_q <= 29'h1000_0000)
		else $error("segment longer than largest block");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("transfer lost at capture stage");
`endif

endmodule
